/* rtl/core/spq_pkg.sv */
// Shared constants, types and codes for the sorted priority queue.
package spq_pkg;

    localparam int CAPACITY      = 16;
    localparam int PRIORITY_BITS = 8;
    localparam int DATA_BITS     = 32;
    localparam int PRIO_IN_BITS  = 8;
    localparam int OCC_BITS      = 5;
    localparam int CNT_BITS      = $clog2(CAPACITY + 1);

    localparam logic CMD_ENQUEUE = 1'b0;
    localparam logic CMD_DEQUEUE = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // Operation broadcast to every cell of the row.
    typedef struct packed {
        logic                     enq;
        logic                     deq;
        logic [PRIORITY_BITS-1:0] pri;
        logic [DATA_BITS-1:0]     data;
    } cell_op_t;

endpackage

/* rtl/core/spq_cell.sv */
// One slot of the sorted row: holds an entry, shifts right on insert, left on pop.
module spq_cell (
    input  logic                                 aclk,
    input  spq_pkg::cell_op_t                    op,
    input  logic                                 slot_valid,
    input  logic                                 left_shift,
    input  logic [spq_pkg::DATA_BITS-1:0]        left_data,
    input  logic [spq_pkg::PRIORITY_BITS-1:0]    left_prio,
    input  logic [spq_pkg::DATA_BITS-1:0]        right_data,
    input  logic [spq_pkg::PRIORITY_BITS-1:0]    right_prio,
    output logic [spq_pkg::DATA_BITS-1:0]        cell_data,
    output logic [spq_pkg::PRIORITY_BITS-1:0]    cell_prio,
    output logic                                 shift_out
);
    import spq_pkg::*;

    logic [DATA_BITS-1:0]     data_reg, data_next;
    logic [PRIORITY_BITS-1:0] prio_reg, prio_next;

    // New entry belongs at or before this slot: empty slot or strictly larger priority.
    assign shift_out = !slot_valid || (prio_reg > op.pri);

    always_comb begin
        data_next = data_reg;
        prio_next = prio_reg;
        if (op.enq) begin
            if (left_shift) begin
                data_next = left_data;
                prio_next = left_prio;
            end else if (shift_out) begin
                data_next = op.data;
                prio_next = op.pri;
            end
        end else if (op.deq) begin
            data_next = right_data;
            prio_next = right_prio;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
        prio_reg <= prio_next;
    end

    assign cell_data = data_reg;
    assign cell_prio = prio_reg;

endmodule

/* rtl/core/sorted_priority_queue.sv */
// Top level of the sorted priority queue: cell row, entry count and result register.
//
// Bounded priority queue of CAPACITY entries kept in ascending priority order in a
// row of compare-and-shift cells. An enqueue item places its entry after every held
// entry of smaller or equal priority (equal priorities leave in arrival order); a
// dequeue item pops the head and returns its data and priority. Every item yields
// exactly one result item with a status (ok, dequeue on empty, enqueue on full), the
// popped data and priority (zero otherwise) and the occupancy after the step, taken
// modulo 32. Throughput is one item per cycle while the output register can take a
// result: every cell compares its priority with the incoming one and moves at once, so
// the row finishes an insert or pop at the accepting edge. The result is registered in
// an output register, and a new item is accepted whenever that register is empty or is
// being drained in the same cycle.
module sorted_priority_queue (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_cmd,
    input  logic signed [spq_pkg::DATA_BITS-1:0]    s_data_in,
    input  logic [spq_pkg::PRIO_IN_BITS-1:0]   s_priority_in,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [1:0]                         m_status,
    output logic signed [spq_pkg::DATA_BITS-1:0]    m_data_out,
    output logic [spq_pkg::PRIO_IN_BITS-1:0]   m_priority_out,
    output logic [spq_pkg::OCC_BITS-1:0]       m_occupancy
);
    import spq_pkg::*;

    logic                     accept;
    logic                     is_full, is_empty;
    cell_op_t                 op;
    logic [CNT_BITS-1:0]      count_reg, count_next;
    logic                     m_valid_reg, m_valid_next;
    status_t                  status_reg, status_next;
    logic [DATA_BITS-1:0]     dout_reg, dout_next;
    logic [PRIORITY_BITS-1:0] pout_reg, pout_next;

    logic [DATA_BITS-1:0]     cell_data  [CAPACITY];
    logic [PRIORITY_BITS-1:0] cell_prio  [CAPACITY];
    logic                     cell_shift [CAPACITY];

    // Accept when the result register is free or drains this cycle.
    assign s_ready  = !m_valid_reg || m_ready;
    assign accept   = s_valid && s_ready;
    assign is_full  = (count_reg == CNT_BITS'(CAPACITY));
    assign is_empty = (count_reg == '0);

    // Broadcast the operation; drop it when it would overflow or underflow.
    always_comb begin
        op.enq  = accept && (s_cmd == CMD_ENQUEUE) && !is_full;
        op.deq  = accept && (s_cmd == CMD_DEQUEUE) && !is_empty;
        op.pri  = PRIORITY_BITS'(s_priority_in);
        op.data = s_data_in;
    end

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic                     left_shift;
        logic [DATA_BITS-1:0]     left_data, right_data;
        logic [PRIORITY_BITS-1:0] left_prio, right_prio;

        if (i == 0) begin : g_head
            assign left_shift = 1'b0;
            assign left_data  = op.data;
            assign left_prio  = op.pri;
        end else begin : g_body
            assign left_shift = cell_shift[i-1];
            assign left_data  = cell_data[i-1];
            assign left_prio  = cell_prio[i-1];
        end

        if (i == CAPACITY - 1) begin : g_tail
            assign right_data = cell_data[i];
            assign right_prio = cell_prio[i];
        end else begin : g_mid
            assign right_data = cell_data[i+1];
            assign right_prio = cell_prio[i+1];
        end

        spq_cell u_cell (
            .aclk       (aclk),
            .op         (op),
            .slot_valid (CNT_BITS'(i) < count_reg),
            .left_shift (left_shift),
            .left_data  (left_data),
            .left_prio  (left_prio),
            .right_data (right_data),
            .right_prio (right_prio),
            .cell_data  (cell_data[i]),
            .cell_prio  (cell_prio[i]),
            .shift_out  (cell_shift[i])
        );
    end

    // Count and result register.
    always_comb begin
        count_next   = count_reg;
        m_valid_next = m_valid_reg;
        status_next  = status_reg;
        dout_next    = dout_reg;
        pout_next    = pout_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (accept) begin
            m_valid_next = 1'b1;
            status_next  = ST_OK;
            dout_next    = '0;
            pout_next    = '0;
            if (s_cmd == CMD_DEQUEUE) begin
                if (is_empty) begin
                    status_next = ST_EMPTY;
                end else begin
                    dout_next  = cell_data[0];
                    pout_next  = cell_prio[0];
                    count_next = count_reg - 1'b1;
                end
            end else begin
                if (is_full) begin
                    status_next = ST_FULL;
                end else begin
                    count_next = count_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
            status_reg  <= ST_OK;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
            status_reg  <= status_next;
        end
        dout_reg <= dout_next;
        pout_reg <= pout_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = status_reg;
    assign m_data_out     = dout_reg;
    assign m_priority_out = PRIO_IN_BITS'(pout_reg);
    assign m_occupancy    = OCC_BITS'(count_reg);

    // Count stays within the row.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_BITS'(CAPACITY))
        else $error("entry count exceeds capacity");

    // Every accepted item leaves a result pending.
    a_result_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_valid_reg)
        else $error("accepted item produced no result");

    // Dequeue on an empty queue reports the error and leaves the count alone.
    a_empty_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_cmd == CMD_DEQUEUE && is_empty) |=>
            (status_reg == ST_EMPTY && count_reg == '0))
        else $error("empty dequeue mishandled");

    // Successful enqueue grows the count by one.
    a_enq_grow: assert property (@(posedge aclk) disable iff (!aresetn)
        op.enq |=> (count_reg == $past(count_reg) + 1'b1 && status_reg == ST_OK))
        else $error("enqueue did not grow the queue");

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the sorted priority queue: random traffic against a predictor.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import spq_pkg::*;

    // Entries in the stimulus list: a real item, or a marker that steers the driver.
    typedef enum logic [1:0] {
        STIM_ITEM,
        STIM_DRAIN,
        STIM_HOLD
    } stim_kind_t;

    typedef struct {
        stim_kind_t                  kind;
        logic                        cmd;
        logic signed [DATA_BITS-1:0] data;
        logic [PRIO_IN_BITS-1:0]     pri;
    } stim_t;

    typedef struct {
        status_t                     status;
        logic signed [DATA_BITS-1:0] data;
        logic [PRIO_IN_BITS-1:0]     pri;
        logic [OCC_BITS-1:0]         occ;
    } queue_result_t;

    // Receiver stall patterns.
    typedef enum logic [1:0] {
        RX_OPEN,
        RX_MOSTLY,
        RX_SPARSE,
        RX_PERIODIC
    } rx_mode_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                        s_valid       = 1'b0;
    logic                        s_ready;
    logic                        s_cmd         = CMD_ENQUEUE;
    logic signed [DATA_BITS-1:0] s_data_in     = '0;
    logic [PRIO_IN_BITS-1:0]     s_priority_in = '0;
    logic                        m_valid;
    logic                        m_ready       = 1'b0;
    logic [1:0]                  m_status;
    logic signed [DATA_BITS-1:0] m_data_out;
    logic [PRIO_IN_BITS-1:0]     m_priority_out;
    logic [OCC_BITS-1:0]         m_occupancy;

    always #2 aclk = ~aclk;

    sorted_priority_queue dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_cmd          (s_cmd),
        .s_data_in      (s_data_in),
        .s_priority_in  (s_priority_in),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_data_out     (m_data_out),
        .m_priority_out (m_priority_out),
        .m_occupancy    (m_occupancy)
    );

    // ------------------------------------------------------------------
    // Predictor: a plain sorted array with its own count.
    // ------------------------------------------------------------------
    logic signed [DATA_BITS-1:0]     held_data [CAPACITY];
    logic [PRIORITY_BITS-1:0]        held_pri  [CAPACITY];
    int                              held_count = 0;
    queue_result_t                   expected_results[$];
    int                              fail_count = 0;

    // Apply one accepted item to the shadow queue and record the result it must produce.
    task automatic apply_queue_op(input logic cmd, input logic signed [DATA_BITS-1:0] data,
                                  input logic [PRIO_IN_BITS-1:0] pri_in);
        queue_result_t            res;
        logic [PRIORITY_BITS-1:0] pri;
        int                       pos;
        pri        = pri_in[PRIORITY_BITS-1:0];
        res.status = ST_OK;
        res.data   = '0;
        res.pri    = '0;
        if (cmd == CMD_DEQUEUE) begin
            if (held_count == 0) begin
                res.status = ST_EMPTY;
            end else begin
                // Pop the head and close the gap.
                res.data = held_data[0];
                res.pri  = PRIO_IN_BITS'(held_pri[0]);
                for (int i = 1; i < held_count; i++) begin
                    held_data[i-1] = held_data[i];
                    held_pri[i-1]  = held_pri[i];
                end
                held_count--;
            end
        end else begin
            if (held_count >= CAPACITY) begin
                res.status = ST_FULL;
            end else begin
                // Skip every entry of smaller or equal priority so ties stay in arrival order.
                pos = 0;
                while (pos < held_count && held_pri[pos] <= pri)
                    pos++;
                for (int i = held_count; i > pos; i--) begin
                    held_data[i] = held_data[i-1];
                    held_pri[i]  = held_pri[i-1];
                end
                held_data[pos] = data;
                held_pri[pos]  = pri;
                held_count++;
            end
        end
        res.occ = OCC_BITS'(held_count);
        expected_results.push_back(res);
    endtask

    task automatic report_mismatch(input string what, input logic [DATA_BITS-1:0] got,
                                   input logic [DATA_BITS-1:0] want);
        $display("%0t ns: MISMATCH %s: got %h, expected %h", $time, what, got, want);
        fail_count++;
    endtask

    // ------------------------------------------------------------------
    // Driver: offer items from the pending list in bursts with gaps.
    // ------------------------------------------------------------------
    stim_t pending_items[$];
    stim_t cur_item;
    logic  offer;
    logic  hold_next;
    logic  hold_req   = 1'b0;
    int    burst_left = 1;
    int    gap_left   = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid  <= 1'b0;
            hold_req <= 1'b0;
        end else begin
            offer     = s_valid;
            hold_next = 1'b0;
            // Predict at the accepting edge; the result cannot come before the next one.
            if (s_valid && s_ready) begin
                apply_queue_op(s_cmd, s_data_in, s_priority_in);
                offer = 1'b0;
            end
            if (!offer && pending_items.size() != 0) begin
                if (pending_items[0].kind == STIM_DRAIN) begin
                    // Hold back until every outstanding result has come home.
                    if (expected_results.size() == 0)
                        cur_item = pending_items.pop_front();
                end else if (pending_items[0].kind == STIM_HOLD) begin
                    // Tell the receiver to stall; keep sending right behind it.
                    hold_next = 1'b1;
                    gap_left  = 0;
                    cur_item  = pending_items.pop_front();
                end else if (gap_left > 0) begin
                    gap_left--;
                end else begin
                    cur_item      = pending_items.pop_front();
                    s_cmd         <= cur_item.cmd;
                    s_data_in     <= cur_item.data;
                    s_priority_in <= cur_item.pri;
                    offer         = 1'b1;
                    burst_left--;
                    if (burst_left <= 0) begin
                        // Start a new burst; a third of them follow with no gap at all.
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
            end
            // One assignment per edge, so a valid that stays high is never dropped and raised.
            s_valid  <= offer;
            hold_req <= hold_next;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: its own stall pattern plus a long counted hold-off on request.
    // ------------------------------------------------------------------
    rx_mode_t rx_mode   = RX_OPEN;
    int       seg_left  = 0;
    int       hold_left = 0;
    int       rx_tick   = 0;
    logic     rdy_next;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (hold_req)
                hold_left = 200;
            if (hold_left > 0) begin
                // Long stall: the output register fills and the input must back off.
                hold_left--;
                rdy_next = 1'b0;
            end else begin
                if (seg_left == 0) begin
                    rx_mode  = rx_mode_t'($urandom_range(0, 3));
                    seg_left = $urandom_range(10, 80);
                end
                seg_left--;
                rx_tick++;
                case (rx_mode)
                    RX_OPEN:   rdy_next = 1'b1;
                    RX_MOSTLY: rdy_next = ($urandom_range(0, 3) != 0);
                    RX_SPARSE: rdy_next = ($urandom_range(0, 3) == 0);
                    default:   rdy_next = rx_tick[2];
                endcase
            end
            m_ready <= rdy_next;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compare each accepted result with the oldest expectation.
    // ------------------------------------------------------------------
    queue_result_t want;

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("result with nothing expected", DATA_BITS'(m_status), '0);
            end else begin
                want = expected_results.pop_front();
                if (m_status !== want.status)
                    report_mismatch("status", DATA_BITS'(m_status), DATA_BITS'(want.status));
                if (m_data_out !== want.data)
                    report_mismatch("data_out", m_data_out, want.data);
                if (m_priority_out !== want.pri)
                    report_mismatch("priority_out", DATA_BITS'(m_priority_out),
                                    DATA_BITS'(want.pri));
                if (m_occupancy !== want.occ)
                    report_mismatch("occupancy", DATA_BITS'(m_occupancy), DATA_BITS'(want.occ));
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus list.
    // ------------------------------------------------------------------
    task automatic add_item(input logic cmd, input logic signed [DATA_BITS-1:0] data,
                            input logic [PRIO_IN_BITS-1:0] pri);
        stim_t st;
        st.kind = STIM_ITEM;
        st.cmd  = cmd;
        st.data = data;
        st.pri  = pri;
        pending_items.push_back(st);
    endtask

    task automatic add_marker(input stim_kind_t kind);
        stim_t st;
        st.kind = kind;
        st.cmd  = CMD_ENQUEUE;
        st.data = '0;
        st.pri  = '0;
        pending_items.push_back(st);
    endtask

    logic [PRIO_IN_BITS-1:0]     dir_pri [16] = '{8'h80, 8'hFF, 8'h00, 8'h00, 8'h80, 8'hFF,
                                                  8'h00, 8'h55, 8'hAA, 8'h01, 8'hFE, 8'h80,
                                                  8'h7F, 8'h80, 8'hFF, 8'h00};
    logic signed [DATA_BITS-1:0] dir_data[4]  = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000,
                                                  32'hFFFF_FFFF};

    initial begin
        int                      enq_pct;
        int                      pri_mode;
        logic                    cmd;
        logic [PRIO_IN_BITS-1:0] pri;

        // Directed: dequeue on empty, fill with extreme data and tied priorities,
        // enqueue on full, then pop a few in order.
        add_item(CMD_DEQUEUE, 32'h8000_0000, 8'hFF);
        for (int i = 0; i < CAPACITY; i++)
            add_item(CMD_ENQUEUE, (i < 4) ? dir_data[i] : $urandom, dir_pri[i % 16]);
        add_item(CMD_ENQUEUE, 32'h5A5A_5A5A, 8'h00);
        for (int i = 0; i < 4; i++)
            add_item(CMD_DEQUEUE, $urandom, PRIO_IN_BITS'($urandom));
        add_marker(STIM_DRAIN);

        // Random phases: each leans toward filling, draining or balance, with its own
        // priority spread so that full, empty and long runs of ties all turn up.
        for (int ph = 0; ph < 10; ph++) begin
            case ($urandom_range(0, 3))
                0:       enq_pct = 25;
                1:       enq_pct = 50;
                2:       enq_pct = 75;
                default: enq_pct = 90;
            endcase
            pri_mode = $urandom_range(0, 2);
            for (int n = 0; n < 123; n++) begin
                cmd = ($urandom_range(0, 99) < enq_pct) ? CMD_ENQUEUE : CMD_DEQUEUE;
                case (pri_mode)
                    0: pri = PRIO_IN_BITS'($urandom);
                    1: pri = PRIO_IN_BITS'($urandom_range(0, 3));
                    default: begin
                        case ($urandom_range(0, 3))
                            0:       pri = 8'h00;
                            1:       pri = 8'hFF;
                            2:       pri = 8'h01;
                            default: pri = 8'hFE;
                        endcase
                    end
                endcase
                add_item(cmd, $urandom, pri);
            end
            if (ph == 3)
                add_marker(STIM_HOLD);
            if (ph == 2 || ph == 5 || ph == 8)
                add_marker(STIM_DRAIN);
        end

        // Reset once, then let the driver run.
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_items.size() != 0 || s_valid || expected_results.size() != 0)
            @(posedge aclk);
        // Watch a few more edges for stray results.
        repeat (10) @(posedge aclk);
        if (expected_results.size() != 0)
            report_mismatch("results never arrived", expected_results.size(), '0);

        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Guard against a hung handshake.
    initial begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

/* files.f */
rtl/core/spq_pkg.sv
rtl/core/spq_cell.sv
rtl/core/sorted_priority_queue.sv
tb/tb_top.sv
